@@ hdl/rmpr_pkg.sv @@
// Shared types, constants and the duty slew function for the reversing motor PWM ramp controller.
// Has no dependencies; every other file in hdl refers to it by scoped names.
package rmpr_pkg;

	localparam int unsigned TIME_W   = 32;
	localparam int unsigned DUTY_W   = 16;
	localparam int unsigned SAMPLE_W = 12;
	localparam int unsigned CFG_W    = 16;
	localparam int unsigned PROD_W   = SAMPLE_W + DUTY_W;
	localparam int unsigned DIV_CNT_W = $clog2(PROD_W);

	localparam int unsigned FIFO_DEPTH = 2;
	localparam int unsigned FIFO_PTR_W = $clog2(FIFO_DEPTH);
	localparam int unsigned FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

	localparam logic [DUTY_W-1:0]   DUTY_MAX_RST       = 16'd999;
	localparam logic [SAMPLE_W-1:0] ADC_FULL_SCALE_RST = 12'd4095;
	localparam logic [DUTY_W-1:0]   RAMP_STEP_RST      = 16'd10;
	localparam logic [DUTY_W-1:0]   REVERSE_DELAY_RST  = 16'd500;

	typedef enum logic [1:0] {
		REG_DUTY_MAX       = 2'd0,
		REG_ADC_FULL_SCALE = 2'd1,
		REG_RAMP_STEP      = 2'd2,
		REG_REVERSE_DELAY  = 2'd3
	} cfg_reg_t;

	typedef enum logic [1:0] {
		PH_STOPPED   = 2'd0,
		PH_RUNNING   = 2'd1,
		PH_RAMP_DOWN = 2'd2,
		PH_REV_WAIT  = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_MUL,
		BK_START,
		BK_DIV,
		BK_COMMIT
	} bk_state_t;

	typedef struct packed {
		logic [DUTY_W-1:0]   duty_max;
		logic [SAMPLE_W-1:0] adc_full_scale;
		logic [DUTY_W-1:0]   ramp_step;
		logic [DUTY_W-1:0]   reverse_delay_ms;
	} cfg_t;

	typedef struct packed {
		logic [TIME_W-1:0]   now_ms;
		logic                run;
		logic                dir;
		logic [SAMPLE_W-1:0] sample;
	} item_t;

	typedef struct packed {
		logic [DUTY_W-1:0]   forward_duty;
		logic [DUTY_W-1:0]   reverse_duty;
		phase_t              phase;
		logic                run_on;
		logic                wanted_reverse;
		logic                driving_reverse;
		logic [DUTY_W-1:0]   target_duty;
		logic [SAMPLE_W-1:0] held_sample;
	} result_t;

	function automatic logic [DUTY_W-1:0] slew(input logic [DUTY_W-1:0] cur,
			input logic [DUTY_W-1:0] goal, input logic [DUTY_W-1:0] step);
		logic [DUTY_W:0]   up;
		logic [DUTY_W-1:0] diff;
		logic [DUTY_W-1:0] r;
		up   = {1'b0, cur} + {1'b0, step};
		diff = cur - goal;
		if (cur < goal) begin
			r = (up > {1'b0, goal}) ? goal : up[DUTY_W-1:0];
		end else if (cur > goal) begin
			r = (diff <= step) ? goal : cur - step;
		end else begin
			r = cur;
		end
		return r;
	endfunction

endpackage

@@ hdl/rmpr_front.sv @@
// Front part: accepts ticks, applies the button toggles and the sample latch, and queues them.
// Depends on rmpr_pkg.
module rmpr_front (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [rmpr_pkg::TIME_W-1:0]      now_ms,
	input  logic                             run_press,
	input  logic                             dir_press,
	input  logic                             sample_valid,
	input  logic [rmpr_pkg::SAMPLE_W-1:0]    adc_sample,
	output logic                             item_empty,
	input  logic                             item_pop,
	output rmpr_pkg::item_t                  item
);

	rmpr_pkg::item_t                       fifo_q [rmpr_pkg::FIFO_DEPTH];
	logic [rmpr_pkg::FIFO_PTR_W-1:0]       wr_ptr_q;
	logic [rmpr_pkg::FIFO_PTR_W-1:0]       rd_ptr_q;
	logic [rmpr_pkg::FIFO_CNT_W-1:0]       count_q;
	logic                                  run_q;
	logic                                  dir_q;
	logic [rmpr_pkg::SAMPLE_W-1:0]         sample_q;
	logic                                  do_push;
	logic                                  do_pop;
	rmpr_pkg::item_t                       new_item;

	assign full       = (count_q == rmpr_pkg::FIFO_CNT_W'(rmpr_pkg::FIFO_DEPTH));
	assign item_empty = (count_q == '0);
	assign do_push    = push && !full;
	assign do_pop     = item_pop && !item_empty;
	assign item       = fifo_q[rd_ptr_q];

	always_comb begin
		new_item.now_ms = now_ms;
		new_item.run    = run_q ^ run_press;
		new_item.dir    = dir_q ^ dir_press;
		new_item.sample = sample_valid ? adc_sample : sample_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q    <= 1'b0;
			dir_q    <= 1'b0;
			sample_q <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				run_q    <= new_item.run;
				dir_q    <= new_item.dir;
				sample_q <= new_item.sample;
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !do_push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= rmpr_pkg::FIFO_CNT_W'(rmpr_pkg::FIFO_DEPTH))
		else $error("front queue count beyond depth");

	a_ptr_track: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) || full || (wr_ptr_q != rd_ptr_q))
		else $error("front queue pointers disagree with count");

	a_run_toggle: assert property (@(posedge clk) disable iff (!arst_n)
		do_push |=> (run_q == ($past(run_q) ^ $past(run_press))))
		else $error("run enable did not follow the press");

endmodule

@@ hdl/rmpr_div.sv @@
// Restoring serial divider, one quotient bit per cycle, used to scale the held sample.
// Depends on rmpr_pkg. A zero divisor yields an all-ones quotient.
module rmpr_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [rmpr_pkg::PROD_W-1:0]      dividend,
	input  logic [rmpr_pkg::SAMPLE_W-1:0]    divisor,
	output logic                             done,
	output logic [rmpr_pkg::PROD_W-1:0]      quotient
);

	logic [rmpr_pkg::SAMPLE_W-1:0]   rem_q;
	logic [rmpr_pkg::PROD_W-1:0]     quo_q;
	logic [rmpr_pkg::DIV_CNT_W-1:0]  cnt_q;
	logic                            busy_q;
	logic                            done_q;
	logic [rmpr_pkg::SAMPLE_W:0]     trial;
	logic                            ge;
	logic [rmpr_pkg::SAMPLE_W:0]     diff;

	assign trial    = {rem_q, quo_q[rmpr_pkg::PROD_W-1]};
	assign ge       = (trial >= {1'b0, divisor});
	assign diff     = trial - {1'b0, divisor};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rmpr_pkg::DIV_CNT_W'(rmpr_pkg::PROD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
		end else if (busy_q) begin
			rem_q <= ge ? diff[rmpr_pkg::SAMPLE_W-1:0] : trial[rmpr_pkg::SAMPLE_W-1:0];
			quo_q <= {quo_q[rmpr_pkg::PROD_W-2:0], ge};
		end
	end

	a_done_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done_q |-> $past(busy_q))
		else $error("divider finished without running");

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !start)
		else $error("divider restarted while busy");

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (cnt_q <= rmpr_pkg::DIV_CNT_W'(rmpr_pkg::PROD_W - 1)))
		else $error("divider step count out of range");

endmodule

@@ hdl/rmpr_back.sv @@
// Back part: scales the sample to a target, runs the phase machine and holds the result.
// Depends on rmpr_pkg and rmpr_div.
module rmpr_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  rmpr_pkg::cfg_t        cfg,
	input  logic                  item_empty,
	output logic                  item_pop,
	input  rmpr_pkg::item_t       item,
	output logic                  empty,
	input  logic                  pop,
	output rmpr_pkg::result_t     result
);

	rmpr_pkg::bk_state_t                 bk_state_q;
	rmpr_pkg::bk_state_t                 bk_state_nxt;
	rmpr_pkg::item_t                     item_q;
	logic [rmpr_pkg::PROD_W-1:0]         product_q;
	logic [rmpr_pkg::DUTY_W-1:0]         target_q;
	rmpr_pkg::phase_t                    phase_q;
	logic                                out_dir_q;
	logic [rmpr_pkg::DUTY_W-1:0]         duty_q;
	logic [rmpr_pkg::TIME_W-1:0]         wait_start_q;
	logic                                out_valid_q;
	rmpr_pkg::result_t                   result_q;

	logic                                div_start;
	logic                                div_done;
	logic [rmpr_pkg::PROD_W-1:0]         div_quo;
	logic                                commit;
	logic                                out_free;

	logic [rmpr_pkg::DUTY_W-1:0]         desired;
	logic                                change;
	logic [rmpr_pkg::DUTY_W-1:0]         goal;
	logic [rmpr_pkg::DUTY_W-1:0]         slewed;
	logic [rmpr_pkg::TIME_W-1:0]         elapsed;
	rmpr_pkg::phase_t                    phase_nxt;
	logic                                dir_nxt;
	logic [rmpr_pkg::DUTY_W-1:0]         duty_nxt;
	logic [rmpr_pkg::TIME_W-1:0]         wait_nxt;

	rmpr_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (product_q),
		.divisor  (cfg.adc_full_scale),
		.done     (div_done),
		.quotient (div_quo)
	);

	assign out_free = !out_valid_q || pop;
	assign empty    = !out_valid_q;
	assign result   = result_q;

	always_comb begin
		bk_state_nxt = bk_state_q;
		unique case (bk_state_q)
			rmpr_pkg::BK_IDLE: begin
				if (!item_empty) begin
					bk_state_nxt = rmpr_pkg::BK_MUL;
				end
			end
			rmpr_pkg::BK_MUL: begin
				bk_state_nxt = rmpr_pkg::BK_START;
			end
			rmpr_pkg::BK_START: begin
				bk_state_nxt = rmpr_pkg::BK_DIV;
			end
			rmpr_pkg::BK_DIV: begin
				if (div_done) begin
					bk_state_nxt = rmpr_pkg::BK_COMMIT;
				end
			end
			rmpr_pkg::BK_COMMIT: begin
				if (out_free) begin
					bk_state_nxt = rmpr_pkg::BK_IDLE;
				end
			end
			default: begin
				bk_state_nxt = rmpr_pkg::BK_IDLE;
			end
		endcase
	end

	always_comb begin
		item_pop  = 1'b0;
		div_start = 1'b0;
		commit    = 1'b0;
		unique case (bk_state_q)
			rmpr_pkg::BK_IDLE:   item_pop  = !item_empty;
			rmpr_pkg::BK_START:  div_start = 1'b1;
			rmpr_pkg::BK_COMMIT: commit    = out_free;
			default: begin
			end
		endcase
	end

	always_comb begin
		desired  = item_q.run ? target_q : '0;
		change   = item_q.run && (item_q.dir != out_dir_q);
		goal     = (phase_q == rmpr_pkg::PH_RUNNING && !change) ? desired : '0;
		slewed   = rmpr_pkg::slew(duty_q, goal, cfg.ramp_step);
		elapsed  = item_q.now_ms - wait_start_q;
		phase_nxt = phase_q;
		dir_nxt   = out_dir_q;
		duty_nxt  = duty_q;
		wait_nxt  = wait_start_q;
		unique case (phase_q)
			rmpr_pkg::PH_STOPPED: begin
				duty_nxt = '0;
				if (change) begin
					dir_nxt = item_q.dir;
				end
				if (desired != '0) begin
					phase_nxt = rmpr_pkg::PH_RUNNING;
				end
			end
			rmpr_pkg::PH_RUNNING: begin
				duty_nxt = slewed;
				if (change) begin
					phase_nxt = rmpr_pkg::PH_RAMP_DOWN;
				end else if (desired == '0 && slewed == '0) begin
					phase_nxt = rmpr_pkg::PH_STOPPED;
				end
			end
			rmpr_pkg::PH_RAMP_DOWN: begin
				duty_nxt = slewed;
				if (slewed == '0) begin
					wait_nxt  = item_q.now_ms;
					phase_nxt = rmpr_pkg::PH_REV_WAIT;
				end
			end
			rmpr_pkg::PH_REV_WAIT: begin
				if (elapsed >= {{(rmpr_pkg::TIME_W-rmpr_pkg::DUTY_W){1'b0}},
						cfg.reverse_delay_ms}) begin
					dir_nxt   = item_q.dir;
					phase_nxt = item_q.run ? rmpr_pkg::PH_RUNNING : rmpr_pkg::PH_STOPPED;
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bk_state_q   <= rmpr_pkg::BK_IDLE;
			phase_q      <= rmpr_pkg::PH_STOPPED;
			out_dir_q    <= 1'b0;
			duty_q       <= '0;
			wait_start_q <= '0;
			out_valid_q  <= 1'b0;
		end else begin
			bk_state_q <= bk_state_nxt;
			if (commit) begin
				phase_q      <= phase_nxt;
				out_dir_q    <= dir_nxt;
				duty_q       <= duty_nxt;
				wait_start_q <= wait_nxt;
				out_valid_q  <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (item_pop) begin
			item_q <= item;
		end
		if (bk_state_q == rmpr_pkg::BK_MUL) begin
			product_q <= rmpr_pkg::PROD_W'(item_q.sample * cfg.duty_max);
		end
		if (div_done) begin
			target_q <= (div_quo > rmpr_pkg::PROD_W'(cfg.duty_max)) ?
				cfg.duty_max : div_quo[rmpr_pkg::DUTY_W-1:0];
		end
		if (commit) begin
			result_q.forward_duty    <= dir_nxt ? '0 : duty_nxt;
			result_q.reverse_duty    <= dir_nxt ? duty_nxt : '0;
			result_q.phase           <= phase_nxt;
			result_q.run_on          <= item_q.run;
			result_q.wanted_reverse  <= item_q.dir;
			result_q.driving_reverse <= dir_nxt;
			result_q.target_duty     <= target_q;
			result_q.held_sample     <= item_q.sample;
		end
	end

	a_idle_duty_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == rmpr_pkg::PH_STOPPED || phase_q == rmpr_pkg::PH_REV_WAIT) |-> (duty_q == '0))
		else $error("duty not zero while stopped or waiting to reverse");

	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> (bk_state_q == rmpr_pkg::BK_DIV))
		else $error("divider result arrived outside the divide step");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pop) |=> ($stable(result_q) && out_valid_q))
		else $error("waiting result was overwritten or dropped");

	a_one_side_driven: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (result_q.forward_duty == '0 || result_q.reverse_duty == '0))
		else $error("both bridge channels driven");

endmodule

@@ hdl/reversing_motor_pwm_ramp_controller_unit.sv @@
// Top level of the reversing motor PWM ramp controller: configuration registers and the parts.
// Depends on rmpr_pkg, rmpr_front and rmpr_back.
//
//   Channel   Direction  Handshake          Carries
//   ticks     in         push / full        now_ms, run_press, dir_press, sample_valid, adc_sample
//   results   out        empty / pop        duties, phase, flags, target_duty, held_sample
//   config    in         cfg_valid/ready    cfg_index, cfg_data
//
// Back part steps per tick: idle, multiply, start, the 28-step serial divide, then commit.
// The front queue holds two ticks, so the source may run ahead of the back part.
// A finished result waits in the output register; only then does the back part stall.
// Reset is asynchronous; queue storage, divider, product, target and result data registers are not reset.
// Configuration transfers are always taken and should only be made while the block is idle.
module reversing_motor_pwm_ramp_controller_unit (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             push,
	output logic                             full,
	input  logic [rmpr_pkg::TIME_W-1:0]      now_ms,
	input  logic                             run_press,
	input  logic                             dir_press,
	input  logic                             sample_valid,
	input  logic [rmpr_pkg::SAMPLE_W-1:0]    adc_sample,
	output logic                             empty,
	input  logic                             pop,
	output logic [rmpr_pkg::DUTY_W-1:0]      forward_duty,
	output logic [rmpr_pkg::DUTY_W-1:0]      reverse_duty,
	output logic [1:0]                       phase_now,
	output logic                             run_on,
	output logic                             wanted_reverse,
	output logic                             driving_reverse,
	output logic [rmpr_pkg::DUTY_W-1:0]      target_duty,
	output logic [rmpr_pkg::SAMPLE_W-1:0]    held_sample,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [rmpr_pkg::CFG_W-1:0]       cfg_data
);

	rmpr_pkg::cfg_t     cfg_q;
	rmpr_pkg::item_t    item;
	logic               item_empty;
	logic               item_pop;
	rmpr_pkg::result_t  result;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.duty_max         <= rmpr_pkg::DUTY_MAX_RST;
			cfg_q.adc_full_scale   <= rmpr_pkg::ADC_FULL_SCALE_RST;
			cfg_q.ramp_step        <= rmpr_pkg::RAMP_STEP_RST;
			cfg_q.reverse_delay_ms <= rmpr_pkg::REVERSE_DELAY_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (rmpr_pkg::cfg_reg_t'(cfg_index))
				rmpr_pkg::REG_DUTY_MAX:       cfg_q.duty_max <= cfg_data;
				rmpr_pkg::REG_ADC_FULL_SCALE:
					cfg_q.adc_full_scale <= cfg_data[rmpr_pkg::SAMPLE_W-1:0];
				rmpr_pkg::REG_RAMP_STEP:      cfg_q.ramp_step <= cfg_data;
				rmpr_pkg::REG_REVERSE_DELAY:  cfg_q.reverse_delay_ms <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	rmpr_front u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.push         (push),
		.full         (full),
		.now_ms       (now_ms),
		.run_press    (run_press),
		.dir_press    (dir_press),
		.sample_valid (sample_valid),
		.adc_sample   (adc_sample),
		.item_empty   (item_empty),
		.item_pop     (item_pop),
		.item         (item)
	);

	rmpr_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.item_empty (item_empty),
		.item_pop   (item_pop),
		.item       (item),
		.empty      (empty),
		.pop        (pop),
		.result     (result)
	);

	assign forward_duty    = result.forward_duty;
	assign reverse_duty    = result.reverse_duty;
	assign phase_now       = result.phase;
	assign run_on          = result.run_on;
	assign wanted_reverse  = result.wanted_reverse;
	assign driving_reverse = result.driving_reverse;
	assign target_duty     = result.target_duty;
	assign held_sample     = result.held_sample;

endmodule
